@@ hw/rtl/hrbs_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP response body splitter package
// Shared constants, result type and the status code decode.
// ----------------------------------------------------------------------------
package hrbs_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] STATUS_LEN = 2'd3;

  typedef logic [2:0][7:0] status_chars_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] body_byte;
    logic [9:0] status_code;
    logic       body_last;
  } result_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // value of the leading decimal digits; 0 until all three are captured
  function automatic logic [9:0] status_value(logic [1:0] cnt, status_chars_t chars);
    logic [3:0] n0;
    logic [3:0] n1;
    logic [3:0] n2;
    logic [9:0] v;
    n0 = chars[0][3:0];
    n1 = chars[1][3:0];
    n2 = chars[2][3:0];
    v  = '0;
    if (cnt == STATUS_LEN && is_digit(chars[0])) begin
      if (is_digit(chars[1])) begin
        if (is_digit(chars[2])) begin
          v = 10'(n0) * 10'd100 + 10'(n1) * 10'd10 + 10'(n2);
        end else begin
          v = 10'(n0) * 10'd10 + 10'(n1);
        end
      end else begin
        v = 10'(n0);
      end
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/hrbs_parser.sv @@
// ----------------------------------------------------------------------------
// HTTP response parser
// Tracks status capture and header end per beat; flags body bytes.
// ----------------------------------------------------------------------------
module hrbs_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat_en,
  input  logic [7:0]       data_byte,
  input  logic             end_of_segment,
  output hrbs_pkg::result_t res
);

  logic                    status_started_r, status_started_nxt;
  logic [1:0]              status_char_count_r, status_char_count_nxt;
  hrbs_pkg::status_chars_t status_chars_r, status_chars_nxt;
  logic                    line_is_blank_r, line_is_blank_nxt;
  logic                    in_body_r, in_body_nxt;
  logic                    body_open_r, body_open_nxt;

  always_comb begin
    status_started_nxt    = status_started_r;
    status_char_count_nxt = status_char_count_r;
    status_chars_nxt      = status_chars_r;
    line_is_blank_nxt     = line_is_blank_r;
    in_body_nxt           = in_body_r;
    body_open_nxt         = body_open_r;

    if (!body_open_r) begin
      if (data_byte == hrbs_pkg::CH_SPACE) begin
        status_started_nxt = 1'b1;
      end
      if (status_started_nxt && status_char_count_r != hrbs_pkg::STATUS_LEN &&
          data_byte != hrbs_pkg::CH_SPACE) begin
        unique case (status_char_count_r)
          2'd0:    status_chars_nxt[0] = data_byte;
          2'd1:    status_chars_nxt[1] = data_byte;
          2'd2:    status_chars_nxt[2] = data_byte;
          default: status_chars_nxt    = status_chars_r;
        endcase
        status_char_count_nxt = status_char_count_r + 2'd1;
      end
    end

    res.valid       = in_body_r;
    res.body_byte   = data_byte;
    res.status_code = hrbs_pkg::status_value(status_char_count_nxt, status_chars_nxt);
    res.body_last   = end_of_segment;

    if (in_body_r) begin
      body_open_nxt = 1'b1;
    end else begin
      if (data_byte == hrbs_pkg::CH_LF && line_is_blank_r) begin
        in_body_nxt = 1'b1;
      end
      if (data_byte == hrbs_pkg::CH_LF) begin
        line_is_blank_nxt = 1'b1;
      end else if (data_byte != hrbs_pkg::CH_CR) begin
        line_is_blank_nxt = 1'b0;
      end
    end

    if (end_of_segment) begin
      status_started_nxt    = 1'b0;
      status_char_count_nxt = '0;
      status_chars_nxt      = '0;
      line_is_blank_nxt     = 1'b0;
      in_body_nxt           = 1'b0;
      body_open_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_started_r    <= 1'b0;
      status_char_count_r <= '0;
      status_chars_r      <= '0;
      line_is_blank_r     <= 1'b0;
      in_body_r           <= 1'b0;
      body_open_r         <= 1'b0;
    end else if (beat_en) begin
      status_started_r    <= status_started_nxt;
      status_char_count_r <= status_char_count_nxt;
      status_chars_r      <= status_chars_nxt;
      line_is_blank_r     <= line_is_blank_nxt;
      in_body_r           <= in_body_nxt;
      body_open_r         <= body_open_nxt;
    end
  end

endmodule

@@ hw/rtl/http_response_body_splitter_top.sv @@
// ----------------------------------------------------------------------------
// HTTP response body splitter
// Splits the body off a received HTTP response segment, tagged with status.
//
// Input channel: one segment byte per beat (in_data_byte), the last byte of
// the segment marked by in_end_of_segment. Output channel: one beat per body
// byte (bytes after the blank line ending the header), carrying the parsed
// three-character status code (0 if incomplete) and out_body_last on the
// segment's final byte. Header bytes produce no output beat.
// A body byte appears on the output in the cycle after it is accepted.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// single output register; a new byte is accepted while the previous result
// is being taken. When the receiver stalls with a result held, in_stall rises
// and the held beat stays unchanged until taken.
// Reset (synchronous, rst_n low) clears all parse state and empties the
// output register; parse state also clears after each segment's last byte.
// ----------------------------------------------------------------------------
module http_response_body_splitter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_segment,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_body_byte,
  output logic [9:0] out_status_code,
  output logic       out_body_last
);

  hrbs_pkg::result_t res;
  logic              beat_en;
  logic              out_valid_r;
  logic [7:0]        body_byte_r;
  logic [9:0]        status_code_r;
  logic              body_last_r;

  assign in_stall = out_valid_r & out_stall;
  assign beat_en  = in_valid & ~in_stall;

  hrbs_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .beat_en        (beat_en),
    .data_byte      (in_data_byte),
    .end_of_segment (in_end_of_segment),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_en) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_en) begin
      body_byte_r   <= res.body_byte;
      status_code_r <= res.status_code;
      body_last_r   <= res.body_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_body_byte   = body_byte_r;
  assign out_status_code = status_code_r;
  assign out_body_last   = body_last_r;

endmodule
